// File: rtl/qcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcs_pkg
// Shared types and constants of the QUICK convection stencil.
// ----------------------------------------------------------------------------
package qcs_pkg;

	// Fraction bits of the Q12.20 format.
	localparam int unsigned FRAC_BITS = 20;

	// Width of the second multiplier operand: wide enough for the stencil
	// combinations such as 3*a - 2*b - c of 32-bit velocities.
	localparam int unsigned OPB_W = 35;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_CELL_WIDTH    = 3'd0,
		REG_CELL_HEIGHT   = 3'd1,
		REG_INV_CELL_AREA = 3'd2,
		REG_INV_TIME_STEP = 3'd3,
		REG_COLUMN_COUNT  = 3'd4,
		REG_ROW_COUNT     = 3'd5
	} reg_idx_t;

	localparam logic [30:0] RST_CELL_WIDTH    = 31'd524288;
	localparam logic [30:0] RST_CELL_HEIGHT   = 31'd524288;
	localparam logic [30:0] RST_INV_CELL_AREA = 31'd4194304;
	localparam logic [30:0] RST_INV_TIME_STEP = 31'd83886080;
	localparam logic [6:0]  RST_COLUMN_COUNT  = 7'd5;
	localparam logic [6:0]  RST_ROW_COUNT     = 7'd8;
	localparam logic [6:0]  MIN_COUNT         = 7'd5;

	// Velocity reads of the stencil, in the order they are fetched.
	localparam logic [2:0] U_C  = 3'd0;
	localparam logic [2:0] U_W  = 3'd1;
	localparam logic [2:0] U_E  = 3'd2;
	localparam logic [2:0] U_WW = 3'd3;
	localparam logic [2:0] U_EE = 3'd4;
	localparam logic [2:0] U_N  = 3'd5;
	localparam logic [2:0] U_NN = 3'd6;
	localparam logic [2:0] U_S  = 3'd7;

	// Sequencer steps of one item.
	localparam int unsigned STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t S_CAP_LO = 5'd1;   // first read data captured
	localparam step_t S_CAP_HI = 5'd8;   // last velocity data captured
	localparam step_t S_CAP_PS = 5'd2;   // south cross pair captured
	localparam step_t S_FW     = 5'd9;   // face fluxes
	localparam step_t S_FE     = 5'd10;
	localparam step_t S_FN     = 5'd11;
	localparam step_t S_FS     = 5'd12;
	localparam step_t S_CW     = 5'd13;  // correction terms
	localparam step_t S_CE     = 5'd14;
	localparam step_t S_CN     = 5'd15;
	localparam step_t S_CS     = 5'd16;
	localparam step_t S_AP     = 5'd18;  // convection products
	localparam step_t S_AW     = 5'd19;
	localparam step_t S_AE     = 5'd20;
	localparam step_t S_AN     = 5'd21;
	localparam step_t S_AS     = 5'd22;
	localparam step_t S_DT     = 5'd23;
	localparam step_t S_GSRC   = 5'd24;
	localparam step_t S_AREA   = 5'd25;
	localparam step_t S_LAST   = 5'd26;

	// Control from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic  load;   // input word accepted this cycle
		logic  run;    // stencil sequence in progress
		logic  emit;   // result goes to the output register
		step_t step;
		logic  first;  // centre at column 0
		logic  last;   // centre at the last column
		logic  xcorr;  // x correction applies
		logic  ycorr;  // y correction applies
	} qcs_ctl_t;

endpackage
`default_nettype wire

// File: rtl/qcs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcs_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module qcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/qcs_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcs_seq
// Raster position, line store addressing and the per-item step sequencer.
// ----------------------------------------------------------------------------
module qcs_seq import qcs_pkg::*; #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [$clog2(MAX_COLUMNS)-1:0]         centre_column,
	output logic [$clog2(MAX_ROWS)-1:0]            centre_row,
	output logic                                   last_of_frame,
	input  wire logic [6:0]                        column_count,
	input  wire logic [6:0]                        row_count,
	output qcs_ctl_t                               ctl,
	output logic                                   wr_en,
	output logic [$clog2(MAX_COLUMNS)+1:0]         vel_raddr,
	output logic [$clog2(MAX_COLUMNS)+1:0]         vel_waddr,
	output logic [$clog2(MAX_COLUMNS)+1:0]         cross_raddr,
	output logic [$clog2(MAX_COLUMNS)+1:0]         cross_waddr,
	output logic [$clog2(MAX_COLUMNS):0]           src_raddr,
	output logic [$clog2(MAX_COLUMNS):0]           src_waddr
);

	localparam int CW   = $clog2(MAX_COLUMNS);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int CNTW = $clog2(MAX_COLUMNS + 1);
	localparam int RNTW = $clog2(MAX_ROWS + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_RUN    = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t          state_q;
	step_t           step_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [1:0]      rmod_q;
	logic            out_valid_q;
	logic [CW-1:0]   ccol_q;
	logic [RW-1:0]   crow_q;
	logic            lof_q;

	logic [CNTW-1:0] cols;
	logic [RNTW-1:0] rows;
	logic            accept;
	logic            col_wrap;
	logic            row_wrap;
	logic            has_res;
	logic            first;
	logic            last;
	logic [RW-1:0]   crow;
	logic            finish_ok;
	logic [1:0]      slot_c;
	logic [1:0]      slot_n;
	logic [1:0]      slot_s;
	logic [1:0]      xslot_c;
	logic [1:0]      vslot;
	logic [CW-1:0]   vcol;

	always_comb begin
		if (column_count < MIN_COUNT) begin
			cols = CNTW'(MIN_COUNT);
		end else if (32'(column_count) > 32'(MAX_COLUMNS)) begin
			cols = CNTW'(MAX_COLUMNS);
		end else begin
			cols = CNTW'(column_count);
		end
		if (row_count < MIN_COUNT) begin
			rows = RNTW'(MIN_COUNT);
		end else if (32'(row_count) > 32'(MAX_ROWS)) begin
			rows = RNTW'(MAX_ROWS);
		end else begin
			rows = RNTW'(row_count);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign col_wrap  = (CNTW'(col_q) >= cols);
	assign row_wrap  = (RNTW'(row_q) >= rows);
	assign has_res   = (row_q >= RW'(4));
	assign first     = (col_q == '0);
	assign last      = (CNTW'(col_q) == cols - CNTW'(1));
	assign crow      = row_q - RW'(2);
	assign finish_ok = (state_q == ST_FINISH) && (!has_res || !out_valid_q || !out_stall);

	always_comb begin
		ctl.load  = accept;
		ctl.run   = (state_q == ST_RUN);
		ctl.emit  = finish_ok && has_res;
		ctl.step  = step_q;
		ctl.first = first;
		ctl.last  = last;
		ctl.xcorr = (col_q > CW'(1)) && ((CNTW+1)'(col_q) + (CNTW+1)'(2) < (CNTW+1)'(cols));
		ctl.ycorr = (crow > RW'(2)) && ((RNTW+1)'(crow) + (RNTW+1)'(3) < (RNTW+1)'(rows));
	end

	// Line store slots relative to the incoming row.
	always_comb begin
		slot_c  = row_q[1:0] - 2'd2;
		slot_n  = row_q[1:0] - 2'd3;
		slot_s  = row_q[1:0] - 2'd1;
		xslot_c = (rmod_q == 2'd2) ? 2'd0 : rmod_q + 2'd1;
		unique case (step_q[2:0])
			U_C:  begin vslot = slot_c;     vcol = col_q;          end
			U_W:  begin vslot = slot_c;     vcol = col_q - CW'(1); end
			U_E:  begin vslot = slot_c;     vcol = col_q + CW'(1); end
			U_WW: begin vslot = slot_c;     vcol = col_q - CW'(2); end
			U_EE: begin vslot = slot_c;     vcol = col_q + CW'(2); end
			U_N:  begin vslot = slot_n;     vcol = col_q;          end
			U_NN: begin vslot = row_q[1:0]; vcol = col_q;          end
			U_S:  begin vslot = slot_s;     vcol = col_q;          end
			default: begin vslot = slot_c;  vcol = col_q;          end
		endcase
	end

	assign vel_raddr   = {vslot, vcol};
	assign cross_raddr = {(step_q == '0) ? rmod_q : xslot_c, col_q};
	assign src_raddr   = {row_q[0], col_q};
	assign vel_waddr   = {row_q[1:0], col_q};
	assign cross_waddr = {rmod_q, col_q};
	assign src_waddr   = {row_q[0], col_q};
	assign wr_en       = finish_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			rmod_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						if (col_wrap) begin
							col_q <= '0;
						end
						if (row_wrap) begin
							row_q  <= '0;
							rmod_q <= '0;
						end
					end
				end
				ST_RUN: begin
					if (!has_res || step_q == S_LAST) begin
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + step_t'(1);
					end
				end
				ST_FINISH: begin
					if (finish_ok) begin
						state_q <= ST_IDLE;
						if ((CNTW+1)'(col_q) + (CNTW+1)'(1) >= (CNTW+1)'(cols)) begin
							col_q <= '0;
							if ((RNTW+1)'(row_q) + (RNTW+1)'(1) >= (RNTW+1)'(rows)) begin
								row_q  <= '0;
								rmod_q <= '0;
							end else begin
								row_q  <= row_q + RW'(1);
								rmod_q <= (rmod_q == 2'd2) ? 2'd0 : rmod_q + 2'd1;
							end
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			ccol_q <= col_q;
			crow_q <= crow;
			lof_q  <= (RNTW'(row_q) == rows - RNTW'(1)) && last;
		end
	end

	assign out_valid     = out_valid_q;
	assign centre_column = ccol_q;
	assign centre_row    = crow_q;
	assign last_of_frame = lof_q;

endmodule
`default_nettype wire

// File: rtl/qcs_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcs_alu
// Stencil operands, shared multiplier and saturating accumulation.
// ----------------------------------------------------------------------------
module qcs_alu import qcs_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire qcs_ctl_t           ctl,
	input  wire logic [30:0]        cell_width,
	input  wire logic [30:0]        cell_height,
	input  wire logic [30:0]        inv_cell_area,
	input  wire logic [30:0]        inv_time_step,
	input  wire logic signed [31:0] u_value,
	input  wire logic signed [31:0] v_left,
	input  wire logic signed [31:0] v_right,
	input  wire logic signed [31:0] source_value,
	input  wire logic [31:0]        vel_rdata,
	input  wire logic [63:0]        cross_rdata,
	input  wire logic [31:0]        src_rdata,
	output logic [31:0]             vel_wdata,
	output logic [63:0]             cross_wdata,
	output logic [31:0]             src_wdata,
	output logic signed [31:0]      g_value
);

	localparam int W     = DATA_WIDTH;
	localparam int OPA_W = (W > 32) ? W : 32;
	localparam int PW    = OPA_W + OPB_W;

	typedef logic signed [W-1:0]     dw_t;
	typedef logic signed [OPB_W-1:0] opb_t;

	localparam opb_t K2 = opb_t'(2);
	localparam opb_t K3 = opb_t'(3);

	function automatic dw_t sat_w(input logic signed [PW-1:0] x);
		logic [PW-W:0] top;
		begin
			top = x[PW-1:W-1];
			if (top == '0 || top == '1) begin
				sat_w = x[W-1:0];
			end else if (x[PW-1]) begin
				sat_w = {1'b1, {(W-1){1'b0}}};
			end else begin
				sat_w = {1'b0, {(W-1){1'b1}}};
			end
		end
	endfunction

	function automatic logic signed [31:0] sat_32(input logic signed [PW-1:0] x);
		logic [PW-32:0] top;
		begin
			top = x[PW-1:31];
			if (top == '0 || top == '1) begin
				sat_32 = x[31:0];
			end else if (x[PW-1]) begin
				sat_32 = 32'sh8000_0000;
			end else begin
				sat_32 = 32'sh7fff_ffff;
			end
		end
	endfunction

	function automatic dw_t sadd(input dw_t a, input dw_t b);
		logic signed [W:0] s;
		begin
			s = (W+1)'(a) + (W+1)'(b);
			if (s[W] != s[W-1]) begin
				sadd = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				sadd = s[W-1:0];
			end
		end
	endfunction

	function automatic dw_t ssub(input dw_t a, input dw_t b);
		logic signed [W:0] s;
		begin
			s = (W+1)'(a) - (W+1)'(b);
			if (s[W] != s[W-1]) begin
				ssub = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				ssub = s[W-1:0];
			end
		end
	endfunction

	logic signed [31:0]      u_in_q;
	logic [63:0]             pair_in_q;
	logic signed [31:0]      src_in_q;
	logic signed [31:0]      uv_q [8];
	logic [63:0]             pn_q;
	logic [63:0]             ps_q;
	logic signed [31:0]      src_q;
	dw_t                     fw_q, fe_q, fn_q, fs_q;
	dw_t                     aw_q, ae_q, an_q, as_q;
	dw_t                     p1_q, p2_q, p3_q, p4_q;
	dw_t                     corr_q, cu_q, g_q;
	logic signed [PW-1:0]    prod_q;
	logic                    half_q;
	logic signed [31:0]      g_value_q;

	logic [2:0]              cap_idx;
	logic signed [OPA_W-1:0] opa;
	opb_t                    opb;
	logic                    half;
	dw_t                     res;
	opb_t                    uc, uw, ue, uww, uee, un, unn, us, uss;
	dw_t                     fwz, fez;

	assign cap_idx = 3'(ctl.step - S_CAP_LO);

	always_comb begin
		uc  = opb_t'(uv_q[U_C]);
		uw  = opb_t'(uv_q[U_W]);
		ue  = opb_t'(uv_q[U_E]);
		uww = opb_t'(uv_q[U_WW]);
		uee = opb_t'(uv_q[U_EE]);
		un  = opb_t'(uv_q[U_N]);
		unn = opb_t'(uv_q[U_NN]);
		us  = opb_t'(uv_q[U_S]);
		uss = opb_t'(u_in_q);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		opa  = '0;
		opb  = '0;
		half = 1'b0;
		case (ctl.step)
			S_FW: begin
				opa = OPA_W'(cell_height); opb = uc + uw; half = 1'b1;
			end
			S_FE: begin
				opa = OPA_W'(cell_height); opb = uc + ue; half = 1'b1;
			end
			S_FN: begin
				opa  = OPA_W'(cell_width);
				opb  = opb_t'($signed(pn_q[31:0])) + opb_t'($signed(pn_q[63:32]));
				half = 1'b1;
			end
			S_FS: begin
				opa  = OPA_W'(cell_width);
				opb  = opb_t'($signed(ps_q[31:0])) + opb_t'($signed(ps_q[63:32]));
				half = 1'b1;
			end
			S_CW: begin
				opa = OPA_W'(fw_q);
				opb = (fw_q > 0) ? K3 * uc - K2 * uw - uww : K3 * uw - K2 * uc - ue;
			end
			S_CE: begin
				opa = OPA_W'(fe_q);
				opb = (fe_q > 0) ? uw + K2 * uc - K3 * ue : K2 * ue + uee - K3 * uc;
			end
			S_CN: begin
				opa = OPA_W'(fn_q);
				opb = (fn_q > 0) ? K3 * uc - K2 * un - unn : K3 * un - K2 * uc - us;
			end
			S_CS: begin
				opa = OPA_W'(fs_q);
				opb = (fs_q > 0) ? un + K2 * uc - K3 * us : K2 * us + uss - K3 * uc;
			end
			S_AP:   begin opa = OPA_W'(p1_q); opb = uc; end
			S_AW:   begin opa = OPA_W'(aw_q); opb = uw; end
			S_AE:   begin opa = OPA_W'(ae_q); opb = ue; end
			S_AN:   begin opa = OPA_W'(an_q); opb = un; end
			S_AS:   begin opa = OPA_W'(as_q); opb = us; end
			S_DT:   begin opa = OPA_W'(inv_time_step); opb = uc; end
			S_AREA: begin opa = OPA_W'(cu_q); opb = opb_t'(inv_cell_area); end
			default: begin
				opa = '0;
			end
		endcase
	end

	// Products round toward minus infinity.
	assign res = sat_w(prod_q >>> (half_q ? FRAC_BITS + 1 : FRAC_BITS));
	assign fwz = ctl.first ? dw_t'(0) : fw_q;
	assign fez = ctl.last ? dw_t'(0) : fe_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			u_in_q    <= u_value;
			pair_in_q <= {v_right, v_left};
			src_in_q  <= source_value;
		end
		if (ctl.emit) begin
			g_value_q <= sat_32(PW'(g_q));
		end
		prod_q <= opa * opb;
		half_q <= half;
		if (ctl.run) begin
			if (ctl.step >= S_CAP_LO && ctl.step <= S_CAP_HI) begin
				if ((cap_idx == U_W && ctl.first) || (cap_idx == U_E && ctl.last)) begin
					uv_q[cap_idx] <= '0;
				end else begin
					uv_q[cap_idx] <= vel_rdata;
				end
			end
			if (ctl.step == S_CAP_LO) begin
				pn_q  <= cross_rdata;
				src_q <= src_rdata;
			end
			if (ctl.step == S_CAP_PS) begin
				ps_q <= cross_rdata;
			end
			case (ctl.step)
				S_FW + step_t'(1): fw_q <= res;
				S_FE + step_t'(1): fe_q <= res;
				S_FN + step_t'(1): fn_q <= res;
				S_FS + step_t'(1): fs_q <= res;
				S_CW + step_t'(1): begin
					corr_q <= ctl.xcorr ? res : dw_t'(0);
					aw_q   <= (fw_q > 0 && !ctl.first) ? fw_q : dw_t'(0);
					ae_q   <= (fe_q > 0 || ctl.last) ? dw_t'(0) : ssub(dw_t'(0), fe_q);
					an_q   <= (fn_q > 0) ? fn_q : dw_t'(0);
					as_q   <= (fs_q > 0) ? dw_t'(0) : ssub(dw_t'(0), fs_q);
				end
				S_CE + step_t'(1): begin
					if (ctl.xcorr) begin
						corr_q <= sadd(corr_q, res);
					end
					p1_q <= sadd(aw_q, ae_q);
					p2_q <= sadd(an_q, as_q);
					p3_q <= ssub(fez, fwz);
					p4_q <= ssub(fs_q, fn_q);
				end
				S_CN + step_t'(1): begin
					if (ctl.ycorr) begin
						corr_q <= sadd(corr_q, res);
					end
					p1_q <= sadd(p1_q, p2_q);
					p3_q <= sadd(p3_q, p4_q);
				end
				S_CS + step_t'(1): begin
					if (ctl.ycorr) begin
						corr_q <= sadd(corr_q, res);
					end
					p1_q <= sadd(p1_q, p3_q);
				end
				S_AP + step_t'(1): cu_q <= res;
				S_AW + step_t'(1): cu_q <= ssub(cu_q, res);
				S_AE + step_t'(1): cu_q <= ssub(cu_q, res);
				S_AN + step_t'(1): cu_q <= ssub(cu_q, res);
				S_AS + step_t'(1): cu_q <= ssub(cu_q, res);
				S_GSRC: begin
					g_q  <= sadd(sat_w(PW'(src_q)), res);
					cu_q <= ssub(cu_q, corr_q >>> 3);
				end
				S_LAST: g_q <= ssub(g_q, res);
				default: ;
			endcase
		end
	end

	assign vel_wdata   = u_in_q;
	assign cross_wdata = pair_in_q;
	assign src_wdata   = src_in_q;
	assign g_value     = g_value_q;

endmodule
`default_nettype wire

// File: rtl/quick_convection_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quick_convection_stencil
// Explicit x-momentum term with first-order upwind convection and QUICK
// deferred correction, computed over line stores of a staggered grid.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | word
//  ---------+---------------------------+-------------------------------------
//  input    | in_valid / in_stall       | u_value, v_left, v_right,
//           |                           | source_value
//  output   | out_valid / out_stall     | g_value, centre_column, centre_row,
//           |                           | last_of_frame
//  config   | APB write/read, 32 bits   | registers at byte address 4*index
//
// A word of the first four rows of a frame gives no result. Any other word
// is worked in steps: eight reads of the velocity line store through its single
// read port, fifteen passes through the one shared multiplier and the saturating
// adder tree that forms the centre coefficient.
// The result for cell (r, c) is formed while the word of cell (r+2, c) is worked.
// Reset clears the raster position and the sequencer; the line stores need no
// clearing, since every entry whose value is used is written before it is read.
// A stalled output word sits in its register while the next input word is taken;
// the following result waits until the register is free.
//
module quick_convection_stencil import qcs_pkg::*; #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input words
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [31:0]            u_value,
	input  wire logic signed [31:0]            v_left,
	input  wire logic signed [31:0]            v_right,
	input  wire logic signed [31:0]            source_value,
	// Result words
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [31:0]                 g_value,
	output logic [$clog2(MAX_COLUMNS)-1:0]     centre_column,
	output logic [$clog2(MAX_ROWS)-1:0]        centre_row,
	output logic                               last_of_frame,
	// Configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [4:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int CW = $clog2(MAX_COLUMNS);

	// Configuration registers. The user must change them only while the block is idle; the block does not enforce this.
	logic [30:0] cell_width_q;
	logic [30:0] cell_height_q;
	logic [30:0] inv_cell_area_q;
	logic [30:0] inv_time_step_q;
	logic [6:0]  column_count_q;
	logic [6:0]  row_count_q;
	reg_idx_t    reg_idx;
	logic        cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q    <= RST_CELL_WIDTH;
			cell_height_q   <= RST_CELL_HEIGHT;
			inv_cell_area_q <= RST_INV_CELL_AREA;
			inv_time_step_q <= RST_INV_TIME_STEP;
			column_count_q  <= RST_COLUMN_COUNT;
			row_count_q     <= RST_ROW_COUNT;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_CELL_WIDTH:    cell_width_q    <= pwdata[30:0];
				REG_CELL_HEIGHT:   cell_height_q   <= pwdata[30:0];
				REG_INV_CELL_AREA: inv_cell_area_q <= pwdata[30:0];
				REG_INV_TIME_STEP: inv_time_step_q <= pwdata[30:0];
				REG_COLUMN_COUNT:  column_count_q  <= pwdata[6:0];
				REG_ROW_COUNT:     row_count_q     <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CELL_WIDTH:    prdata = {1'b0, cell_width_q};
			REG_CELL_HEIGHT:   prdata = {1'b0, cell_height_q};
			REG_INV_CELL_AREA: prdata = {1'b0, inv_cell_area_q};
			REG_INV_TIME_STEP: prdata = {1'b0, inv_time_step_q};
			REG_COLUMN_COUNT:  prdata = {25'b0, column_count_q};
			REG_ROW_COUNT:     prdata = {25'b0, row_count_q};
			default:           prdata = '0;
		endcase
	end

	// Sequencer and line store addressing.
	qcs_ctl_t       ctl;
	logic           wr_en;
	logic [CW+1:0]  vel_raddr, vel_waddr, cross_raddr, cross_waddr;
	logic [CW:0]    src_raddr, src_waddr;
	logic [31:0]    vel_rdata, vel_wdata, src_rdata, src_wdata;
	logic [63:0]    cross_rdata, cross_wdata;

	qcs_seq #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.centre_column (centre_column),
		.centre_row    (centre_row),
		.last_of_frame (last_of_frame),
		.column_count  (column_count_q),
		.row_count     (row_count_q),
		.ctl           (ctl),
		.wr_en         (wr_en),
		.vel_raddr     (vel_raddr),
		.vel_waddr     (vel_waddr),
		.cross_raddr   (cross_raddr),
		.cross_waddr   (cross_waddr),
		.src_raddr     (src_raddr),
		.src_waddr     (src_waddr)
	);

	// Four rows of x-velocity, three rows of y-velocity pairs, two rows of source.
	qcs_ram #(.WIDTH(32), .DEPTH(4 << CW)) u_vel_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (vel_waddr),
		.wdata (vel_wdata),
		.raddr (vel_raddr),
		.rdata (vel_rdata)
	);

	qcs_ram #(.WIDTH(64), .DEPTH(3 << CW)) u_cross_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cross_waddr),
		.wdata (cross_wdata),
		.raddr (cross_raddr),
		.rdata (cross_rdata)
	);

	qcs_ram #(.WIDTH(32), .DEPTH(2 << CW)) u_src_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (src_waddr),
		.wdata (src_wdata),
		.raddr (src_raddr),
		.rdata (src_rdata)
	);

	// Arithmetic over the fetched stencil.
	qcs_alu #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_alu (
		.clk           (clk),
		.ctl           (ctl),
		.cell_width    (cell_width_q),
		.cell_height   (cell_height_q),
		.inv_cell_area (inv_cell_area_q),
		.inv_time_step (inv_time_step_q),
		.u_value       (u_value),
		.v_left        (v_left),
		.v_right       (v_right),
		.source_value  (source_value),
		.vel_rdata     (vel_rdata),
		.cross_rdata   (cross_rdata),
		.src_rdata     (src_rdata),
		.vel_wdata     (vel_wdata),
		.cross_wdata   (cross_wdata),
		.src_wdata     (src_wdata),
		.g_value       (g_value)
	);

endmodule
`default_nettype wire

// File: bench/quick_convection_stencil_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quick_convection_stencil_tb
// Streams whole frames of staggered-grid cells through the stencil under
// several register settings. Every result word is checked against a
// predictor of the upwind convection term with QUICK correction.
// ----------------------------------------------------------------------------
module quick_convection_stencil_tb;
	import qcs_pkg::*;

	localparam int NCOL = 64;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	// One expected result word.
	typedef struct {
		longint g;
		int     col;
		int     row;
		bit     last;
	} stencil_result_t;

	// The scoreboard keeps its own copy of the registers and line stores,
	// predicts results for accepted cells from row 4 on and checks them in order.
	class stencil_scoreboard;
		longint dx, dy, inv_area, inv_dt;
		int col_reg, row_reg;
		longint u_rows[4*NCOL];
		longint vl_rows[3*NCOL];
		longint vr_rows[3*NCOL];
		longint src_rows[2*NCOL];
		int col_pos, row_pos;
		stencil_result_t pending_g[$];
		int errors, checked;

		function void reset_state();
			dx = RST_CELL_WIDTH;
			dy = RST_CELL_HEIGHT;
			inv_area = RST_INV_CELL_AREA;
			inv_dt = RST_INV_TIME_STEP;
			col_reg = RST_COLUMN_COUNT;
			row_reg = RST_ROW_COUNT;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(reg_idx_t idx, longint value);
			case (idx)
				REG_CELL_WIDTH:    dx = value & 64'h7fffffff;
				REG_CELL_HEIGHT:   dy = value & 64'h7fffffff;
				REG_INV_CELL_AREA: inv_area = value & 64'h7fffffff;
				REG_INV_TIME_STEP: inv_dt = value & 64'h7fffffff;
				REG_COLUMN_COUNT:  col_reg = value & 64'h7f;
				REG_ROW_COUNT:     row_reg = value & 64'h7f;
				default: ;
			endcase
		endfunction

		function longint sat32(longint x);
			return x > S32_MAX ? S32_MAX : (x < S32_MIN ? S32_MIN : x);
		endfunction

		// Full-width product, floor shift, then saturation to the data width.
		function longint prod_shift(longint a, longint b, int sh);
			logic signed [127:0] p;
			p = a;
			p = p * b;
			p = p >>> sh;
			if (p > 128'sd2147483647) return S32_MAX;
			if (p < -128'sd2147483648) return S32_MIN;
			return longint'(p);
		endfunction

		function longint face_term(longint f, longint up, longint down);
			return prod_shift(f, f > 0 ? up : down, 20);
		endfunction

		function int clamp_count(int v);
			return v < 5 ? 5 : (v > NCOL ? NCOL : v);
		endfunction

		function void note_input(longint u_in, longint vl_in, longint vr_in, longint s_in);
			int cols, rows, c, r, s_c, s_n, s_nn, s_s, vc, vn, cr;
			bit first, last;
			longint uc, uw, ue, un, unn, us, src, fw, fe, fn, fs, aw, ae, an, as_c;
			longint corr, ap, cu, g, uww, uee;
			stencil_result_t res;
			cols = clamp_count(col_reg);
			rows = clamp_count(row_reg);
			if (col_pos >= cols) col_pos = 0;
			if (row_pos >= rows) row_pos = 0;
			c = col_pos;
			r = row_pos;
			if (r >= 4) begin
				s_c = ((r - 2) & 3) * NCOL;
				s_n = ((r - 3) & 3) * NCOL;
				s_nn = (r & 3) * NCOL;
				s_s = ((r - 1) & 3) * NCOL;
				vc = ((r - 2) % 3) * NCOL;
				vn = ((r - 3) % 3) * NCOL;
				cr = r - 2;
				first = (c == 0);
				last = (c == cols - 1);
				uc = u_rows[s_c + c];
				uw = first ? 0 : u_rows[s_c + c - 1];
				ue = last ? 0 : u_rows[s_c + c + 1];
				un = u_rows[s_n + c];
				unn = u_rows[s_nn + c];
				us = u_rows[s_s + c];
				src = src_rows[(r & 1) * NCOL + c];
				fw = prod_shift(dy, uc + uw, 21);
				fe = prod_shift(dy, uc + ue, 21);
				fn = prod_shift(dx, vl_rows[vn + c] + vr_rows[vn + c], 21);
				fs = prod_shift(dx, vl_rows[vc + c] + vr_rows[vc + c], 21);
				aw = fw > 0 ? fw : 0;
				ae = fe > 0 ? 0 : sat32(-fe);
				an = fn > 0 ? fn : 0;
				as_c = fs > 0 ? 0 : sat32(-fs);
				corr = 0;
				// The x correction needs two cells on each side of the centre.
				if (c > 1 && c + 2 < cols) begin
					uww = u_rows[s_c + c - 2];
					uee = u_rows[s_c + c + 2];
					corr = sat32(face_term(fw, 3*uc - 2*uw - uww, 3*uw - 2*uc - ue)
						+ face_term(fe, uw + 2*uc - 3*ue, 2*ue + uee - 3*uc));
				end
				if (cr > 2 && cr + 3 < rows) begin
					corr = sat32(corr + face_term(fn, 3*uc - 2*un - unn, 3*un - 2*uc - us));
					corr = sat32(corr + face_term(fs, un + 2*uc - 3*us, 2*us + u_in - 3*uc));
				end
				if (first) begin
					aw = 0;
					fw = 0;
				end
				if (last) begin
					ae = 0;
					fe = 0;
				end
				ap = sat32(sat32(sat32(aw + ae) + sat32(an + as_c))
					+ sat32(sat32(fe - fw) + sat32(fs - fn)));
				cu = prod_shift(ap, uc, 20);
				cu = sat32(cu - prod_shift(aw, uw, 20));
				cu = sat32(cu - prod_shift(ae, ue, 20));
				cu = sat32(cu - prod_shift(an, un, 20));
				cu = sat32(cu - prod_shift(as_c, us, 20));
				cu = sat32(cu - (corr >>> 3));
				g = sat32(src + prod_shift(uc, inv_dt, 20));
				g = sat32(g - prod_shift(cu, inv_area, 20));
				res.g = g;
				res.col = c;
				res.row = cr;
				res.last = (r == rows - 1) && last;
				pending_g.push_back(res);
			end
			u_rows[(r & 3) * NCOL + c] = u_in;
			vl_rows[(r % 3) * NCOL + c] = vl_in;
			vr_rows[(r % 3) * NCOL + c] = vr_in;
			src_rows[(r & 1) * NCOL + c] = s_in;
			if (c + 1 >= cols) begin
				col_pos = 0;
				row_pos = (r + 1 >= rows) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function void check_result(longint g, int col, int row, bit last);
			stencil_result_t e;
			if (pending_g.size() == 0) begin
				$error("result word with none expected: g_value %0d", g);
				errors++;
				return;
			end
			e = pending_g.pop_front();
			checked++;
			if (e.g != g) begin
				$error("g_value expected %0d actual %0d", e.g, g);
				errors++;
			end
			if (e.col != col) begin
				$error("centre_column expected %0d actual %0d", e.col, col);
				errors++;
			end
			if (e.row != row) begin
				$error("centre_row expected %0d actual %0d", e.row, row);
				errors++;
			end
			if (e.last != last) begin
				$error("last_of_frame expected %0d actual %0d", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic signed [31:0] u_value = '0;
	logic signed [31:0] v_left = '0;
	logic signed [31:0] v_right = '0;
	logic signed [31:0] source_value = '0;
	logic out_stall = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire in_stall, out_valid, last_of_frame, pready;
	wire signed [31:0] g_value;
	wire [5:0] centre_column, centre_row;
	wire [31:0] prdata;

	stencil_scoreboard sb;
	// When calm is set, neither side idles at random.
	bit calm = 1'b0;
	// Each increment asks the result side for one long hold-off.
	int hold_requests = 0;
	int frames_run = 0;
	int words_sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	quick_convection_stencil i_dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .u_value, .v_left, .v_right, .source_value,
		.out_valid, .out_stall, .g_value, .centre_column, .centre_row, .last_of_frame,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	// Result side: random stalls, plus a long hold-off on request, counted in
	// cycles here so that the sender keeps offering words meanwhile.
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 10);
		end
	end

	// Every accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(g_value, centre_column, centre_row, last_of_frame);
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, value);
	endtask

	task automatic send_cell(logic [31:0] u, logic [31:0] vl, logic [31:0] vr,
			logic [31:0] s);
		if (!calm && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		u_value <= u;
		v_left <= vl;
		v_right <= vr;
		source_value <= s;
		do @(posedge clk); while (in_stall);
		sb.note_input(longint'($signed(u)), longint'($signed(vl)),
			longint'($signed(vr)), longint'($signed(s)));
		words_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending_g.size() != 0) @(posedge clk);
		// Words of the early rows give no result yet may still be in flight.
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value(bit full);
		if (full) return $urandom;
		return 32'($signed($urandom_range(0, 32'h3fffff)) - 32'sh200000);
	endfunction

	// One whole frame of random cells; when pause_mid is set the sender waits
	// halfway until every expected result has arrived.
	task automatic run_frame(bit full, bit pause_mid);
		int cells;
		cells = sb.clamp_count(sb.col_reg) * sb.clamp_count(sb.row_reg);
		for (int k = 0; k < cells; k++) begin
			if (pause_mid && k == cells / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (sb.pending_g.size() != 0);
			end
			send_cell(rand_value(full), rand_value(full), rand_value(full),
				rand_value(full));
		end
		frames_run++;
		wait_drained();
	endtask

	initial begin
		logic [31:0] extremes[6];
		sb = new();
		sb.reset_state();
		extremes = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h00100000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frame of 5 by 5 cells with the field extremes; the velocities
		// cycle through six values, among them both sign extremes, to drive both upwind directions.
		reg_write(REG_ROW_COUNT, 5);
		for (int k = 0; k < 25; k++)
			send_cell(extremes[k % 6], extremes[(k + 1) % 6], extremes[(k + 3) % 6],
				extremes[(k + 5) % 6]);
		frames_run++;
		wait_drained();

		for (int p = 0; words_sent < 1800; p++) begin
			case (p)
				0: begin
					reg_write(REG_CELL_WIDTH, 32'h7fffffff);
					reg_write(REG_CELL_HEIGHT, 32'h7fffffff);
					reg_write(REG_INV_CELL_AREA, 32'h7fffffff);
					reg_write(REG_INV_TIME_STEP, 32'h7fffffff);
					reg_write(REG_COLUMN_COUNT, 8);
					reg_write(REG_ROW_COUNT, 9);
				end
				1: begin
					reg_write(REG_CELL_WIDTH, 1);
					reg_write(REG_CELL_HEIGHT, 1);
					reg_write(REG_INV_CELL_AREA, 1);
					reg_write(REG_INV_TIME_STEP, 1);
				end
				2: begin
					reg_write(REG_COLUMN_COUNT, 64);
					reg_write(REG_ROW_COUNT, 5);
				end
				3: begin
					// Counts outside the legal range act clamped.
					reg_write(REG_COLUMN_COUNT, 0);
					reg_write(REG_ROW_COUNT, 127);
				end
				default: begin
					reg_write(REG_CELL_WIDTH, $urandom_range(1 << 16, 1 << 21));
					reg_write(REG_CELL_HEIGHT, $urandom_range(1 << 16, 1 << 21));
					reg_write(REG_INV_CELL_AREA, $urandom_range(1 << 18, 1 << 24));
					reg_write(REG_INV_TIME_STEP, $urandom_range(1 << 18, 1 << 26));
					reg_write(REG_COLUMN_COUNT, $urandom_range(5, 12));
					reg_write(REG_ROW_COUNT, $urandom_range(5, 12));
				end
			endcase
			calm = (p == 5);
			if (p == 6) hold_requests++;
			run_frame(p < 2 || $urandom_range(99) < 30, p == 7);
		end
		calm = 1'b0;

		wait_drained();
		$display("Covered %0d frames, %0d cells and %0d checked result words.",
			frames_run, words_sent, sb.checked);
		if (sb.errors == 0 && sb.pending_g.size() == 0)
			$display("quick_convection_stencil regression: pass");
		else
			$display("quick_convection_stencil regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("quick_convection_stencil regression: fail");
		$finish;
	end

endmodule
